FILE: rtl/ihdepq_pkg.sv
`default_nettype none
package ihdepq_pkg;

  localparam int unsigned KEY_PORT_W = 32;

  localparam logic [1:0] OP_PUSH    = 2'd0;
  localparam logic [1:0] OP_POP_MIN = 2'd1;
  localparam logic [1:0] OP_POP_MAX = 2'd2;

  localparam logic [1:0] STATUS_DONE  = 2'd0;
  localparam logic [1:0] STATUS_EMPTY = 2'd1;
  localparam logic [1:0] STATUS_FULL  = 2'd2;

  typedef enum logic [1:0] {
    CMD_HOLD,
    CMD_INSERT,
    CMD_SHIFT
  } cell_cmd_e;

  typedef struct packed {
    cell_cmd_e               cmd;
    logic [KEY_PORT_W-1:0]   key;
  } cell_ctrl_t;

endpackage
`default_nettype wire

FILE: rtl/ihdepq_cell.sv
`default_nettype none
module ihdepq_cell
  import ihdepq_pkg::*;
#(
  parameter int unsigned IDX   = 0,
  parameter int unsigned CNT_W = 11,
  parameter int unsigned KW    = 32,
  parameter bit          DESC  = 1'b0
) (
  input  wire logic             clk_i,
  input  wire cell_ctrl_t       ctrl_i,
  input  wire logic [CNT_W-1:0] count_i,
  input  wire logic             prev_gt_i,
  input  wire logic [KW-1:0]    prev_key_i,
  input  wire logic [KW-1:0]    next_key_i,
  output logic                  gt_o,
  output logic [KW-1:0]         key_o
);

  logic [KW-1:0] key_q, key_d;
  logic [KW-1:0] new_key;
  logic          occ;
  logic          after;

  // gt_o: new key goes at or before this cell (empty cells count as after)
  assign new_key = ctrl_i.key[KW-1:0];
  assign occ     = CNT_W'(IDX) < count_i;
  assign after   = DESC ? (key_q < new_key) : (key_q > new_key);
  assign gt_o    = !occ || after;
  assign key_o   = key_q;

  always_comb begin
    key_d = key_q;
    case (ctrl_i.cmd)
      CMD_INSERT: begin
        if (prev_gt_i) begin
          key_d = prev_key_i;
        end else if (gt_o) begin
          key_d = new_key;
        end
      end
      CMD_SHIFT: key_d = next_key_i;
      default:   key_d = key_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
  end

endmodule
`default_nettype wire

FILE: rtl/interval_heap_depq_unit.sv
// Double-ended priority queue of unsigned keys.
// Input channel (in_valid_i/in_ready_o): operation_i selects push of value_i,
// remove minimum or remove maximum; code 3 is a no-op.
// Output channel (out_valid_o/out_ready_i): one result item per input item,
// in order: status_o, min_value_o, max_value_o, count_o, is_empty_o.
// Keys live in two rows of CAPACITY cells, one sorted ascending and one
// descending; each item is one compare-and-shift step across both rows,
// cells taking data only from their neighbors or from the new key at the input.
// Throughput: one item per cycle while the receiver takes results. The rows
// and fill count update at the accept edge; the result register then loads
// from them once the output register is free.
// Reset clears the fill count and the output handshake; the queue is empty.
// When the receiver stalls, one result waits in the output register and one
// more item may be taken into the pending stage; then in_ready_o drops until
// the output is taken.
// Push on a full queue returns status full, pop on an empty queue returns
// status empty; the contents stay unchanged in both cases.
`default_nettype none
module interval_heap_depq_unit
  import ihdepq_pkg::*;
#(
  parameter int unsigned CAPACITY  = 1024,
  parameter int unsigned KEY_WIDTH = 32
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_ready_o,
  input  wire logic [1:0]            operation_i,
  input  wire logic [KEY_PORT_W-1:0] value_i,
  output logic                       out_valid_o,
  input  wire logic                  out_ready_i,
  output logic [1:0]                 status_o,
  output logic [KEY_PORT_W-1:0]      min_value_o,
  output logic [KEY_PORT_W-1:0]      max_value_o,
  output logic [$clog2(CAPACITY+1)-1:0] count_o,
  output logic                       is_empty_o
);

  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
  localparam int unsigned KW    = (KEY_WIDTH < KEY_PORT_W) ? KEY_WIDTH : KEY_PORT_W;

  logic [CNT_W-1:0] count_q, count_d;
  logic             accept;
  logic             out_free;
  logic             load_out;
  logic             pend_q;
  logic [1:0]       pend_status_q;
  logic [1:0]       status_d;
  logic             out_valid_q;
  logic [1:0]       status_q;
  logic [KW-1:0]    min_q, max_q;
  logic [CNT_W-1:0] cnt_out_q;
  logic             empty_q;

  cell_ctrl_t       ctrl [2];
  logic             gt   [2][CAPACITY];
  logic [KW-1:0]    key  [2][CAPACITY];
  logic             pgt  [2][CAPACITY];
  logic [KW-1:0]    pkey [2][CAPACITY];
  logic [KW-1:0]    nkey [2][CAPACITY];

  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = !pend_q || out_free;
  assign accept     = in_valid_i && in_ready_o;
  assign load_out   = pend_q && out_free;

  always_comb begin
    ctrl[0].cmd = CMD_HOLD;
    ctrl[0].key = value_i;
    ctrl[1].cmd = CMD_HOLD;
    ctrl[1].key = value_i;
    count_d     = count_q;
    status_d    = STATUS_DONE;
    if (accept) begin
      case (operation_i)
        OP_PUSH: begin
          if (count_q == CNT_W'(CAPACITY)) begin
            status_d = STATUS_FULL;
          end else begin
            ctrl[0].cmd = CMD_INSERT;
            ctrl[1].cmd = CMD_INSERT;
            count_d     = count_q + CNT_W'(1);
          end
        end
        OP_POP_MIN: begin
          if (count_q == '0) begin
            status_d = STATUS_EMPTY;
          end else begin
            ctrl[0].cmd = CMD_SHIFT;
            count_d     = count_q - CNT_W'(1);
          end
        end
        OP_POP_MAX: begin
          if (count_q == '0) begin
            status_d = STATUS_EMPTY;
          end else begin
            ctrl[1].cmd = CMD_SHIFT;
            count_d     = count_q - CNT_W'(1);
          end
        end
        default: ;
      endcase
    end
  end

  // row 0 ascending (minimum at cell 0), row 1 descending (maximum at cell 0)
  for (genvar r = 0; r < 2; r++) begin : g_row
    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      if (i == 0) begin : g_first
        assign pgt[r][i]  = 1'b0;
        assign pkey[r][i] = ctrl[r].key[KW-1:0];
      end else begin : g_mid
        assign pgt[r][i]  = gt[r][i-1];
        assign pkey[r][i] = key[r][i-1];
      end
      if (i == CAPACITY - 1) begin : g_last
        assign nkey[r][i] = key[r][i];
      end else begin : g_inner
        assign nkey[r][i] = key[r][i+1];
      end

      ihdepq_cell #(
        .IDX   (i),
        .CNT_W (CNT_W),
        .KW    (KW),
        .DESC  (r == 1)
      ) u_cell (
        .clk_i      (clk_i),
        .ctrl_i     (ctrl[r]),
        .count_i    (count_q),
        .prev_gt_i  (pgt[r][i]),
        .prev_key_i (pkey[r][i]),
        .next_key_i (nkey[r][i]),
        .gt_o       (gt[r][i]),
        .key_o      (key[r][i])
      );
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (accept) begin
        pend_q <= 1'b1;
      end else if (load_out) begin
        pend_q <= 1'b0;
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      pend_status_q <= status_d;
    end
    if (load_out) begin
      status_q  <= pend_status_q;
      min_q     <= (count_q == '0) ? '0 : key[0][0];
      max_q     <= (count_q == '0) ? '0 : key[1][0];
      cnt_out_q <= count_q;
      empty_q   <= (count_q == '0);
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;
  assign min_value_o = KEY_PORT_W'(min_q);
  assign max_value_o = KEY_PORT_W'(max_q);
  assign count_o     = cnt_out_q;
  assign is_empty_o  = empty_q;

endmodule
`default_nettype wire

FILE: sim/tb.sv
`default_nettype none
module tb;
  import ihdepq_pkg::*;

  localparam int unsigned CAPACITY = 1024;
  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
  localparam int unsigned QUIET_LIMIT = 2000;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam logic [1:0] OP_NONE = 2'd3;

  typedef struct packed {
    logic [1:0]            status;
    logic [KEY_PORT_W-1:0] min_key;
    logic [KEY_PORT_W-1:0] max_key;
    logic [CNT_W-1:0]      fill;
    logic                  empty;
  } report_t;

  // Interval heap copy: even slot = larger key of a node, odd slot = smaller.
  class depq_mirror;
    logic [KEY_PORT_W-1:0] slot [CAPACITY];
    int unsigned fill;
    report_t pending [$];
    int unsigned mismatches;
    int unsigned checked;
    int unsigned peak_fill;
    int unsigned full_rejects;
    int unsigned empty_rejects;

    function void swap(int unsigned a, int unsigned b);
      logic [KEY_PORT_W-1:0] t;
      t = slot[a];
      slot[a] = slot[b];
      slot[b] = t;
    endfunction

    function int unsigned sift_up(int unsigned k);
      int unsigned p;
      if ((k | 1) != fill && slot[k & ~1] < slot[k | 1]) begin
        swap(k, k ^ 1);
        k = k ^ 1;
      end
      while (k > 1) begin
        p = ((k >> 1) - 1) & ~1;
        if (!(slot[p] < slot[k])) break;
        swap(p, k);
        k = p;
      end
      while (k > 1) begin
        p = (((k >> 1) - 1) & ~1) | 1;
        if (!(slot[k] < slot[p])) break;
        swap(p, k);
        k = p;
      end
      return k;
    endfunction

    function int unsigned sift_down(int unsigned k);
      int unsigned i;
      if (k & 1) begin
        while (2 * k + 1 < fill) begin
          i = 2 * k + 3;
          if (fill <= i || slot[i - 2] < slot[i]) i = i - 2;
          if (fill <= i || !(slot[i] < slot[k])) break;
          swap(i, k);
          k = i;
        end
      end else begin
        while (2 * k + 2 < fill) begin
          i = 2 * k + 4;
          if (fill <= i || slot[i] < slot[i - 2]) i = i - 2;
          if (fill <= i || !(slot[k] < slot[i])) break;
          swap(i, k);
          k = i;
        end
      end
      return k;
    endfunction

    function void take_item(logic [1:0] op, logic [KEY_PORT_W-1:0] key);
      report_t r;
      r.status = STATUS_DONE;
      case (op)
        OP_PUSH: begin
          if (fill >= CAPACITY) begin
            r.status = STATUS_FULL;
            full_rejects++;
          end else begin
            slot[fill] = key;
            fill++;
            void'(sift_up(fill - 1));
          end
        end
        OP_POP_MIN: begin
          if (fill == 0) begin
            r.status = STATUS_EMPTY;
            empty_rejects++;
          end else if (fill < 3) begin
            fill--;
          end else begin
            swap(1, fill - 1);
            fill--;
            void'(sift_up(sift_down(1)));
          end
        end
        OP_POP_MAX: begin
          if (fill == 0) begin
            r.status = STATUS_EMPTY;
            empty_rejects++;
          end else if (fill < 2) begin
            fill--;
          end else begin
            swap(0, fill - 1);
            fill--;
            void'(sift_up(sift_down(0)));
          end
        end
        default: ;
      endcase
      if (fill > peak_fill) peak_fill = fill;
      r.min_key = '0;
      r.max_key = '0;
      if (fill > 0) begin
        r.max_key = slot[0];
        r.min_key = slot[fill > 1 ? 1 : 0];
      end
      r.fill = CNT_W'(fill);
      r.empty = (fill == 0);
      pending.insert(pending.size(), r);
    endfunction

    function void check_field(string name, logic [KEY_PORT_W-1:0] want,
                              logic [KEY_PORT_W-1:0] got);
      if (want !== got) begin
        $error("%s: expected %0h, got %0h", name, want, got);
        mismatches++;
      end
    endfunction

    function void check_report(report_t got);
      report_t want;
      if (pending.size() == 0) begin
        $error("result item with no input item pending");
        mismatches++;
        return;
      end
      want = pending.pop_front();
      checked++;
      check_field("status", KEY_PORT_W'(want.status), KEY_PORT_W'(got.status));
      check_field("min_value", want.min_key, got.min_key);
      check_field("max_value", want.max_key, got.max_key);
      check_field("count", KEY_PORT_W'(want.fill), KEY_PORT_W'(got.fill));
      check_field("is_empty", KEY_PORT_W'(want.empty), KEY_PORT_W'(got.empty));
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic [1:0] operation_i = OP_NONE;
  logic [KEY_PORT_W-1:0] value_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic [1:0] status_o;
  logic [KEY_PORT_W-1:0] min_value_o;
  logic [KEY_PORT_W-1:0] max_value_o;
  logic [CNT_W-1:0] count_o;
  logic is_empty_o;

  depq_mirror shadow;
  int unsigned send_idle_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned items_sent = 0;
  int unsigned quiet_cycles = 0;

  interval_heap_depq_unit #(
    .CAPACITY (CAPACITY),
    .KEY_WIDTH(KEY_PORT_W)
  ) uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .operation_i(operation_i),
    .value_i    (value_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .status_o   (status_o),
    .min_value_o(min_value_o),
    .max_value_o(max_value_o),
    .count_o    (count_o),
    .is_empty_o (is_empty_o)
  );

  always #2 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i)
      shadow.check_report({status_o, min_value_o, max_value_o, count_o, is_empty_o});
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  function automatic logic [KEY_PORT_W-1:0] pick_key();
    logic [KEY_PORT_W-1:0] k;
    case ($urandom_range(9))
      0: k = '0;
      1: k = '1;
      2, 3: k = KEY_PORT_W'($urandom_range(15));
      4: k = {{(KEY_PORT_W-4){1'b1}}, 4'($urandom_range(15))};
      default: k = $urandom;
    endcase
    return k;
  endfunction

  task automatic send_item(input logic [1:0] op, input logic [KEY_PORT_W-1:0] key);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    operation_i <= op;
    value_i <= key;
    do @(posedge clk_i); while (!in_ready_o);
    shadow.take_item(op, key);
    items_sent++;
  endtask

  // push_pct of items push, 2% do nothing, the rest pop either end
  task automatic random_items(input int unsigned n, input int unsigned push_pct,
                              input bit until_full);
    int unsigned r;
    logic [1:0] op;
    for (int unsigned i = 0; i < n; i++) begin
      if (until_full && shadow.fill >= CAPACITY) break;
      r = $urandom_range(99);
      if (r < push_pct) op = OP_PUSH;
      else if (r >= 98) op = OP_NONE;
      else if (r[0]) op = OP_POP_MIN;
      else op = OP_POP_MAX;
      send_item(op, pick_key());
    end
  endtask

  initial begin
    shadow = new();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // empty store, single key, duplicates and extreme keys
    send_item(OP_POP_MIN, '0);
    send_item(OP_POP_MAX, '1);
    send_item(OP_NONE, 32'h0000_0042);
    send_item(OP_PUSH, 32'd5);
    send_item(OP_NONE, 32'hFFFF_FFFF);
    send_item(OP_POP_MAX, '0);
    send_item(OP_PUSH, 32'hFFFF_FFFF);
    send_item(OP_PUSH, 32'h0000_0000);
    send_item(OP_PUSH, 32'h0000_0000);
    send_item(OP_PUSH, 32'h7FFF_FFFF);
    send_item(OP_PUSH, 32'h8000_0000);
    send_item(OP_POP_MIN, '0);
    send_item(OP_POP_MAX, '0);
    send_item(OP_POP_MIN, '0);
    send_item(OP_POP_MAX, '0);
    send_item(OP_POP_MIN, '0);
    send_item(OP_POP_MAX, '0);
    send_item(OP_PUSH, 32'h1234_5678);
    send_item(OP_POP_MIN, '0);
    send_item(OP_PUSH, 32'hAAAA_AAAA);
    send_item(OP_PUSH, 32'h5555_5555);
    send_item(OP_POP_MAX, '0);
    send_item(OP_POP_MAX, '0);

    random_items(200, 48, 1'b0);

    send_idle_pct = 52;
    random_items(1400, 96, 1'b1);

    send_idle_pct = 0;
    stall_pct = 52;
    random_items(40, 70, 1'b0);
    random_items(250, 25, 1'b0);

    send_idle_pct = 6;
    stall_pct = 6;
    random_items(250, 50, 1'b0);

    in_valid_i <= 1'b0;
    while (shadow.pending.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Checked %0d results over %0d items; peak fill %0d of %0d keys.",
             shadow.checked, items_sent, shadow.peak_fill, CAPACITY);
    $display("Rejected pushes on full store: %0d, rejected pops on empty store: %0d.",
             shadow.full_rejects, shadow.empty_rejects);
    if (shadow.mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
`default_nettype wire

FILE: filelist.f
rtl/ihdepq_pkg.sv
rtl/ihdepq_cell.sv
rtl/interval_heap_depq_unit.sv
sim/tb.sv
